[hw/rtl/tmop_pkg.sv]
// ---------------------------------------------------------------------------
// TCP MSS option parser package
// Shared constants and types for the option byte walker and its stages.
// ---------------------------------------------------------------------------
package tmop_pkg;

   // Reset value of the local MSS register.
   localparam logic [15:0] MSS_RESET = 16'd1460;

   // Option kinds that the walker treats specially.
   localparam logic [7:0] KIND_END = 8'd0;
   localparam logic [7:0] KIND_NOP = 8'd1;
   localparam logic [7:0] KIND_MSS = 8'd2;

   // Option lengths: the only valid MSS length and the smallest legal length.
   localparam logic [7:0] MSS_OPT_LEN = 8'd4;
   localparam logic [7:0] MIN_OPT_LEN = 8'd2;

   // Parse phase codes: which kind of byte the walker is waiting for.
   localparam logic [2:0] PH_KIND   = 3'd0;
   localparam logic [2:0] PH_LEN    = 3'd1;
   localparam logic [2:0] PH_MSS_HI = 3'd2;
   localparam logic [2:0] PH_MSS_LO = 3'd3;
   localparam logic [2:0] PH_SKIP   = 3'd4;
   localparam logic [2:0] PH_DONE   = 3'd5;

   // One option byte as it travels from the input register to the parser.
   typedef struct packed {
      logic [7:0] opt_byte;
      logic       last;
   } opt_item_type;

   // One result item for a finished segment.
   typedef struct packed {
      logic [15:0] mss_limit;
      logic        mss_found;
      logic        malformed;
   } mss_result_type;

endpackage

[hw/rtl/tmop_in_reg.sv]
// ---------------------------------------------------------------------------
// TCP MSS option parser input register
// Holds one accepted option byte until the parser can move it onward.
// ---------------------------------------------------------------------------
module tmop_in_reg (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  tmop_pkg::opt_item_type req_item,
   input  logic                  advance,
   output logic                  item_valid,
   output tmop_pkg::opt_item_type item
);

   logic                   valid_ff;
   logic                   valid_in;
   tmop_pkg::opt_item_type item_ff;
   logic                   accept;

   // The register takes a new item when it is empty or is emptied this cycle.
   assign req_ready = !valid_ff || advance;
   assign accept    = req_valid && req_ready;

   always_comb begin
      valid_in = valid_ff;
      if (accept) begin
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // The payload needs no reset; it is qualified by the valid bit.
   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff <= req_item;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

[hw/rtl/tmop_parser.sv]
// ---------------------------------------------------------------------------
// TCP MSS option parser core
// Walks kind and length fields one byte per take cycle; keeps the MSS limit.
// ---------------------------------------------------------------------------
module tmop_parser (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_write_enable,
   input  logic [15:0]             csr_write_data,
   input  logic                    take,
   input  tmop_pkg::opt_item_type  item,
   output logic                    result_valid,
   output tmop_pkg::mss_result_type result
);

   logic [2:0]  phase_ff, phase_in;
   logic        is_mss_ff, is_mss_in;
   logic [7:0]  skip_ff, skip_in;
   logic [7:0]  high_ff, high_in;
   logic [15:0] limit_ff, limit_in;
   logic [15:0] local_mss_ff, local_mss_in;
   logic        saw_ff, saw_in;
   logic        bad_ff, bad_in;
   logic [15:0] mss_value;
   logic        cut_off;

   assign mss_value = {high_ff, item.opt_byte};

   // Next state for one option byte.
   always_comb begin
      phase_in     = phase_ff;
      is_mss_in    = is_mss_ff;
      skip_in      = skip_ff;
      high_in      = high_ff;
      limit_in     = limit_ff;
      saw_in       = saw_ff;
      bad_in       = bad_ff;
      local_mss_in = local_mss_ff;
      if (take) begin
         case (phase_ff)
            tmop_pkg::PH_KIND: begin
               if (item.opt_byte == tmop_pkg::KIND_END) begin
                  phase_in = tmop_pkg::PH_DONE;
               end else if (item.opt_byte != tmop_pkg::KIND_NOP) begin
                  is_mss_in = (item.opt_byte == tmop_pkg::KIND_MSS);
                  phase_in  = tmop_pkg::PH_LEN;
               end
            end
            tmop_pkg::PH_LEN: begin
               if (item.opt_byte < tmop_pkg::MIN_OPT_LEN) begin
                  bad_in   = 1'b1;
                  phase_in = tmop_pkg::PH_DONE;
               end else if (is_mss_ff && item.opt_byte == tmop_pkg::MSS_OPT_LEN) begin
                  phase_in = tmop_pkg::PH_MSS_HI;
               end else if (item.opt_byte == tmop_pkg::MIN_OPT_LEN) begin
                  phase_in = tmop_pkg::PH_KIND;
               end else begin
                  skip_in  = item.opt_byte - tmop_pkg::MIN_OPT_LEN;
                  phase_in = tmop_pkg::PH_SKIP;
               end
            end
            tmop_pkg::PH_MSS_HI: begin
               high_in  = item.opt_byte;
               phase_in = tmop_pkg::PH_MSS_LO;
            end
            tmop_pkg::PH_MSS_LO: begin
               if (mss_value < limit_ff) begin
                  limit_in = mss_value;
               end
               saw_in   = 1'b1;
               phase_in = tmop_pkg::PH_KIND;
            end
            tmop_pkg::PH_SKIP: begin
               skip_in = skip_ff - 8'd1;
               if (skip_ff == 8'd1) begin
                  phase_in = tmop_pkg::PH_KIND;
               end
            end
            default: begin
               phase_in = tmop_pkg::PH_DONE;
            end
         endcase
      end

      // An option still owing bytes at the end of the area is malformed.
      cut_off = phase_in inside {tmop_pkg::PH_LEN, tmop_pkg::PH_MSS_HI,
                                 tmop_pkg::PH_MSS_LO, tmop_pkg::PH_SKIP};
      result.mss_limit = limit_in;
      result.mss_found = saw_in;
      result.malformed = bad_in || cut_off;
      result_valid     = take && item.last;

      // The last byte closes the segment and the walker starts over.
      if (take && item.last) begin
         phase_in  = tmop_pkg::PH_KIND;
         is_mss_in = 1'b0;
         skip_in   = 8'd0;
         high_in   = 8'd0;
         limit_in  = local_mss_ff;
         saw_in    = 1'b0;
         bad_in    = 1'b0;
      end

      // A register write also restarts the running limit.
      if (csr_write_enable) begin
         local_mss_in = csr_write_data;
         limit_in     = csr_write_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= tmop_pkg::PH_KIND;
         is_mss_ff    <= 1'b0;
         skip_ff      <= 8'd0;
         high_ff      <= 8'd0;
         limit_ff     <= tmop_pkg::MSS_RESET;
         local_mss_ff <= tmop_pkg::MSS_RESET;
         saw_ff       <= 1'b0;
         bad_ff       <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         is_mss_ff    <= is_mss_in;
         skip_ff      <= skip_in;
         high_ff      <= high_in;
         limit_ff     <= limit_in;
         local_mss_ff <= local_mss_in;
         saw_ff       <= saw_in;
         bad_ff       <= bad_in;
      end
   end

   // The running limit never rises above the configured local MSS.
   a_limit_bound: assert property (@(posedge clock) disable iff (reset)
      limit_ff <= local_mss_ff)
      else $error("running MSS limit exceeds local MSS");

   // The last byte leaves the walker at the start of a fresh segment.
   a_segment_restart: assert property (@(posedge clock) disable iff (reset)
      take && item.last |=> phase_ff == tmop_pkg::PH_KIND && !saw_ff && !bad_ff)
      else $error("segment state not restarted after last byte");

   // A short length byte in the middle of the area flags the segment.
   a_short_length: assert property (@(posedge clock) disable iff (reset)
      take && !item.last && phase_ff == tmop_pkg::PH_LEN
      && item.opt_byte < tmop_pkg::MIN_OPT_LEN
      |=> bad_ff && phase_ff == tmop_pkg::PH_DONE)
      else $error("short option length not flagged");

endmodule

[hw/rtl/tmop_out_reg.sv]
// ---------------------------------------------------------------------------
// TCP MSS option parser result register
// Holds one result item until the receiver takes it.
// ---------------------------------------------------------------------------
module tmop_out_reg (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     load,
   input  tmop_pkg::mss_result_type result,
   output logic                     can_load,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output tmop_pkg::mss_result_type rsp_result
);

   logic                     valid_ff;
   logic                     valid_in;
   tmop_pkg::mss_result_type result_ff;

   // A new result may enter when the register is empty or drains this cycle.
   assign can_load = !valid_ff || rsp_ready;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         result_ff <= result;
      end
   end

   assign rsp_valid  = valid_ff;
   assign rsp_result = result_ff;

endmodule

[hw/rtl/tcp_mss_option_parser_top.sv]
// ---------------------------------------------------------------------------
// TCP MSS option parser
// Reduces the TCP option bytes of one segment to an MSS limit.
// ---------------------------------------------------------------------------
// Usage:
//   The request channel carries one option byte per item, with req_last high
//   on the final byte of a segment. Only the last byte produces a response
//   item: the MSS limit, whether a length-4 MSS option was seen, and whether
//   an option was malformed (length under two or cut off by the end).
//   The last byte waits in the input register and is decoded into the result
//   register, which drives rsp_valid. Throughput is one byte per cycle while
//   the result register has room; the decode between those two registers is
//   combinational.
//   csr_write_enable loads local_mss, which is the starting limit of every
//   segment; write it only while no segment is in progress.
//   Reset empties both registers, returns the walker to the start of a
//   segment and sets local_mss to 1460.
//   When the receiver stalls, the waiting result holds and one more byte can
//   sit in the input register; req_ready then drops until rsp_ready rises.
// ---------------------------------------------------------------------------
module tcp_mss_option_parser_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_opt_byte,
   input  logic        req_last,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [15:0] rsp_mss_limit,
   output logic        rsp_mss_found,
   output logic        rsp_malformed,
   input  logic        csr_write_enable,
   input  logic [15:0] csr_write_data
);

   tmop_pkg::opt_item_type   req_item;
   tmop_pkg::opt_item_type   item;
   tmop_pkg::mss_result_type result;
   tmop_pkg::mss_result_type rsp_result;
   logic                     item_valid;
   logic                     advance;
   logic                     can_load;
   logic                     result_valid;

   assign req_item.opt_byte = req_opt_byte;
   assign req_item.last     = req_last;

   // A byte moves through the decoder when the result register has room.
   assign advance = item_valid && can_load;

   tmop_in_reg u_in_reg (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_item   (req_item),
      .advance    (advance),
      .item_valid (item_valid),
      .item       (item)
   );

   tmop_parser u_parser (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .take             (advance),
      .item             (item),
      .result_valid     (result_valid),
      .result           (result)
   );

   tmop_out_reg u_out_reg (
      .clock      (clock),
      .reset      (reset),
      .load       (result_valid),
      .result     (result),
      .can_load   (can_load),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_result (rsp_result)
   );

   assign rsp_mss_limit = rsp_result.mss_limit;
   assign rsp_mss_found = rsp_result.mss_found;
   assign rsp_malformed = rsp_result.malformed;

endmodule

[test/tb_top.sv]
// ---------------------------------------------------------------------------
// TCP MSS option parser testbench
// Drives segments of option bytes into the parser and checks each response
// item against a typed-in result or a byte-level walker kept in the
// testbench. A short table of hand-picked segments comes first. Random
// segments then follow, mostly well-formed with some broken ones, over
// several local MSS settings and idle patterns.
// ---------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   // One row of the directed table. The typed-in result is used only where
   // has_want is set; other rows rely on the walker.
   typedef struct {
      logic [7:0]               opt_byte;
      logic                     last;
      bit                       has_want;
      tmop_pkg::mss_result_type want;
   } opt_row_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [7:0]  req_opt_byte;
   logic        req_last;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [15:0] rsp_mss_limit;
   logic        rsp_mss_found;
   logic        rsp_malformed;
   logic        csr_write_enable;
   logic [15:0] csr_write_data;

   // Walker state, a copy of what the parser keeps per segment.
   logic [15:0] local_mss_now;
   logic [2:0]  walk_phase;
   logic [7:0]  cur_kind;
   logic [7:0]  skip_left;
   logic [7:0]  mss_hi;
   logic [15:0] limit_now;
   logic        mss_seen;
   logic        opt_bad;

   tmop_pkg::mss_result_type owed_results[$];
   logic [7:0]               seg_bytes[$];
   int                       mismatch_count = 0;
   int                       send_idle_pct = 0;
   int                       recv_idle_pct = 0;

   // Directed segments, run with the reset value of local MSS.
   opt_row_type directed_rows[25] = '{
      // End of list alone.
      '{8'h00, 1'b1, 1'b1, {16'd1460, 1'b0, 1'b0}},
      // MSS 0x0500 is below 1460 and replaces the limit.
      '{8'h02, 1'b0, 1'b0, 18'd0},
      '{8'h04, 1'b0, 1'b0, 18'd0},
      '{8'h05, 1'b0, 1'b0, 18'd0},
      '{8'h00, 1'b1, 1'b1, {16'd1280, 1'b1, 1'b0}},
      // NOP, then the largest MSS, which leaves the limit alone.
      '{8'h01, 1'b0, 1'b0, 18'd0},
      '{8'h02, 1'b0, 1'b0, 18'd0},
      '{8'h04, 1'b0, 1'b0, 18'd0},
      '{8'hFF, 1'b0, 1'b0, 18'd0},
      '{8'hFF, 1'b1, 1'b1, {16'd1460, 1'b1, 1'b0}},
      // Length one is malformed and the byte after it is ignored.
      '{8'hFF, 1'b0, 1'b0, 18'd0},
      '{8'h01, 1'b0, 1'b0, 18'd0},
      '{8'h02, 1'b1, 1'b1, {16'd1460, 1'b0, 1'b1}},
      // MSS kind with length three is skipped as an unknown option.
      '{8'h02, 1'b0, 1'b0, 18'd0},
      '{8'h03, 1'b0, 1'b0, 18'd0},
      '{8'h00, 1'b1, 1'b0, 18'd0},
      // MSS option cut off by the end of the area.
      '{8'h02, 1'b0, 1'b0, 18'd0},
      '{8'h04, 1'b0, 1'b0, 18'd0},
      '{8'h01, 1'b1, 1'b1, {16'd1460, 1'b0, 1'b1}},
      // Bytes after end of list are ignored.
      '{8'h00, 1'b0, 1'b0, 18'd0},
      '{8'h02, 1'b1, 1'b1, {16'd1460, 1'b0, 1'b0}},
      // MSS of zero.
      '{8'h02, 1'b0, 1'b0, 18'd0},
      '{8'h04, 1'b0, 1'b0, 18'd0},
      '{8'h00, 1'b0, 1'b0, 18'd0},
      '{8'h00, 1'b1, 1'b1, {16'd0, 1'b1, 1'b0}}
   };

   tcp_mss_option_parser_top dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_opt_byte     (req_opt_byte),
      .req_last         (req_last),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_mss_limit    (rsp_mss_limit),
      .rsp_mss_found    (rsp_mss_found),
      .rsp_malformed    (rsp_malformed),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   // Clock with a 20 ns period.
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Start of a segment: the limit goes back to the local MSS.
   function automatic void restart_walk();
      walk_phase = tmop_pkg::PH_KIND;
      cur_kind   = 8'd0;
      skip_left  = 8'd0;
      mss_hi     = 8'd0;
      limit_now  = local_mss_now;
      mss_seen   = 1'b0;
      opt_bad    = 1'b0;
   endfunction

   // Takes one option byte and returns 1 with the response item on the
   // last byte of a segment.
   function automatic bit walk_option_byte(input logic [7:0] b, input logic l,
                                           output tmop_pkg::mss_result_type res);
      logic [15:0] adv;
      res = '0;
      case (walk_phase)
         tmop_pkg::PH_KIND: begin
            if (b == tmop_pkg::KIND_END) begin
               walk_phase = tmop_pkg::PH_DONE;
            end else if (b != tmop_pkg::KIND_NOP) begin
               cur_kind   = b;
               walk_phase = tmop_pkg::PH_LEN;
            end
         end
         tmop_pkg::PH_LEN: begin
            if (b < tmop_pkg::MIN_OPT_LEN) begin
               opt_bad    = 1'b1;
               walk_phase = tmop_pkg::PH_DONE;
            end else if (cur_kind == tmop_pkg::KIND_MSS && b == tmop_pkg::MSS_OPT_LEN) begin
               walk_phase = tmop_pkg::PH_MSS_HI;
            end else if (b == tmop_pkg::MIN_OPT_LEN) begin
               walk_phase = tmop_pkg::PH_KIND;
            end else begin
               skip_left  = b - tmop_pkg::MIN_OPT_LEN;
               walk_phase = tmop_pkg::PH_SKIP;
            end
         end
         tmop_pkg::PH_MSS_HI: begin
            mss_hi     = b;
            walk_phase = tmop_pkg::PH_MSS_LO;
         end
         tmop_pkg::PH_MSS_LO: begin
            adv = {mss_hi, b};
            if (adv < limit_now) limit_now = adv;
            mss_seen   = 1'b1;
            walk_phase = tmop_pkg::PH_KIND;
         end
         tmop_pkg::PH_SKIP: begin
            skip_left = skip_left - 8'd1;
            if (skip_left == 8'd0) walk_phase = tmop_pkg::PH_KIND;
         end
         default: begin
            walk_phase = tmop_pkg::PH_DONE;
         end
      endcase
      if (!l) return 1'b0;
      // An option still owing bytes at the end of the area is malformed.
      if (walk_phase != tmop_pkg::PH_KIND && walk_phase != tmop_pkg::PH_DONE)
         opt_bad = 1'b1;
      res.mss_limit = limit_now;
      res.mss_found = mss_seen;
      res.malformed = opt_bad;
      restart_walk();
      return 1'b1;
   endfunction

   // Builds one random segment in seg_bytes. Most options are well formed;
   // a few are broken, cut off or plain noise.
   function automatic void build_segment();
      int          n_opts;
      int          pick;
      int          len;
      logic [15:0] adv;
      seg_bytes.delete();
      n_opts = $urandom_range(0, 4);
      for (int i = 0; i < n_opts; i++) begin
         pick = $urandom_range(99);
         if (pick < 20) begin
            seg_bytes.push_back(tmop_pkg::KIND_NOP);
         end else if (pick < 55) begin
            case ($urandom_range(3))
               0: adv = 16'($urandom_range(16'hFFFF));
               1: adv = 16'(local_mss_now + $urandom_range(2) - 1);
               2: adv = $urandom_range(1) ? 16'hFFFF : 16'h0000;
               default: adv = 16'($urandom_range(536, 1500));
            endcase
            seg_bytes.push_back(tmop_pkg::KIND_MSS);
            seg_bytes.push_back(tmop_pkg::MSS_OPT_LEN);
            seg_bytes.push_back(adv[15:8]);
            seg_bytes.push_back(adv[7:0]);
         end else if (pick < 82) begin
            // Unknown option, or an MSS option of the wrong length.
            if (pick < 75) begin
               seg_bytes.push_back(8'($urandom_range(3, 255)));
               len = ($urandom_range(9) == 0) ? $urandom_range(2, 40) : $urandom_range(2, 8);
            end else begin
               seg_bytes.push_back(tmop_pkg::KIND_MSS);
               len = $urandom_range(2, 8);
               if (len == tmop_pkg::MSS_OPT_LEN) len = 3;
            end
            seg_bytes.push_back(8'(len));
            for (int k = 2; k < len; k++) seg_bytes.push_back(8'($urandom_range(255)));
         end else if (pick < 88) begin
            seg_bytes.push_back(tmop_pkg::KIND_END);
            for (int k = $urandom_range(3); k > 0; k--)
               seg_bytes.push_back(8'($urandom_range(255)));
            break;
         end else if (pick < 93) begin
            seg_bytes.push_back(8'($urandom_range(2, 255)));
            seg_bytes.push_back(8'($urandom_range(1)));
            for (int k = $urandom_range(2); k > 0; k--)
               seg_bytes.push_back(8'($urandom_range(255)));
            break;
         end else begin
            for (int k = $urandom_range(1, 4); k > 0; k--)
               seg_bytes.push_back(8'($urandom_range(255)));
         end
      end
      // Sometimes cut the area short in the middle of an option.
      if (seg_bytes.size() > 1 && $urandom_range(9) == 0)
         seg_bytes = seg_bytes[0:$urandom_range(seg_bytes.size() - 2)];
      if (seg_bytes.size() == 0) seg_bytes.push_back(8'($urandom_range(255)));
   endfunction

   // Offers one item and waits for it to be taken. The handshake is read at
   // the falling edge, where all signals are settled.
   task automatic send_byte(input logic [7:0] b, input logic l, input bit has_want,
                            input tmop_pkg::mss_result_type want);
      logic                     taken;
      tmop_pkg::mss_result_type predicted;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_opt_byte <= b;
      req_last     <= l;
      taken = 1'b0;
      while (!taken) begin
         @(negedge clock);
         taken = req_ready;
         @(posedge clock);
      end
      if (walk_option_byte(b, l, predicted))
         owed_results.push_back(has_want ? want : predicted);
   endtask

   // Writes local MSS once every owed item is back and the pipe has drained.
   task automatic set_local_mss(input logic [15:0] value);
      req_valid <= 1'b0;
      while (owed_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      local_mss_now = value;
      limit_now     = value;
   endtask

   // Receiver: ready drops at random according to the current idle rate.
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // Response checker.
   always @(negedge clock) begin
      tmop_pkg::mss_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (owed_results.size() == 0) begin
            $error("response item with no expected item: mss_limit %0d", rsp_mss_limit);
            mismatch_count++;
         end else begin
            want = owed_results.pop_front();
            if (rsp_mss_limit !== want.mss_limit) begin
               $error("mss_limit: expected %0d, got %0d", want.mss_limit, rsp_mss_limit);
               mismatch_count++;
            end
            if (rsp_mss_found !== want.mss_found) begin
               $error("mss_found: expected %0b, got %0b", want.mss_found, rsp_mss_found);
               mismatch_count++;
            end
            if (rsp_malformed !== want.malformed) begin
               $error("malformed: expected %0b, got %0b", want.malformed, rsp_malformed);
               mismatch_count++;
            end
         end
      end
   end

   // Main sequence.
   initial begin
      logic [15:0] mss_settings[6];
      int          sent;
      reset            <= 1'b1;
      req_valid        <= 1'b0;
      req_opt_byte     <= 8'd0;
      req_last         <= 1'b0;
      csr_write_enable <= 1'b0;
      csr_write_data   <= 16'd0;
      local_mss_now = tmop_pkg::MSS_RESET;
      restart_walk();
      mss_settings = '{16'hFFFF, 16'h0000, 16'h0000, 16'd536, 16'h0000, 16'h0001};
      mss_settings[2] = 16'($urandom_range(16'hFFFF));
      mss_settings[4] = 16'($urandom_range(1, 3000));
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed table, walked with the first idle pattern.
      send_idle_pct = 27;
      recv_idle_pct = 64;
      foreach (directed_rows[i])
         send_byte(directed_rows[i].opt_byte, directed_rows[i].last,
                   directed_rows[i].has_want, directed_rows[i].want);

      // Random segments: two local MSS settings for each idle pattern.
      for (int ph = 0; ph < 6; ph++) begin
         send_idle_pct = (ph < 2) ? 27 : (ph < 4) ? 64 : 0;
         recv_idle_pct = (ph < 2) ? 64 : (ph < 4) ? 27 : 0;
         set_local_mss(mss_settings[ph]);
         sent = 0;
         while (sent < 100) begin
            build_segment();
            foreach (seg_bytes[k])
               send_byte(seg_bytes[k], k == seg_bytes.size() - 1, 1'b0, '0);
            sent += seg_bytes.size();
         end
      end

      // Drain and report.
      req_valid <= 1'b0;
      while (owed_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("tb_top passed");
      end else begin
         $display("tb_top failed");
      end
      $finish;
   end

   // Run limit.
   initial begin
      #5000000;
      $display("tb_top failed");
      $finish;
   end

endmodule
